// ===== rtl/core/jhd_pkg.sv =====
// ---------------------------------------------------------------------------
// jhd_pkg: shared types and constants of the Huffman table decoder
// Field widths, transaction modes, status codes and the control structs
// exchanged between the loader, the bit decoder and the top level.
// ---------------------------------------------------------------------------
package jhd_pkg;

   // default sizing, handed to the top-level parameters
   localparam int DEF_MAX_CODE_LEN = 16;
   localparam int DEF_MAX_SYMBOLS  = 256;

   // fixed field widths
   localparam int BYTE_W   = 8;
   localparam int ACC_W    = 17;  // code accumulator
   localparam int LEN_W    = 5;   // code length / bit count
   localparam int POS_W    = 9;   // load position, bytes_loaded
   localparam int TOTAL_W  = 12;  // sum of all count bytes
   localparam int STATUS_W = 3;
   localparam int BASE_W   = 9;   // symbol index arithmetic
   localparam int FREE_CAP = 256; // free leaves saturate here, above any count

   typedef enum logic [1:0] {
      MODE_RESTART = 2'd0,
      MODE_TABLE   = 2'd1,
      MODE_BIT     = 2'd2,
      MODE_UNUSED  = 2'd3
   } jhd_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_TOO_MANY = 3'd1,
      ST_OVERSUB  = 3'd2,
      ST_INVALID  = 3'd3,
      ST_NO_TABLE = 3'd4
   } jhd_status_type;

   // one row of the canonical code table
   typedef struct packed {
      logic [BYTE_W-1:0] count;
      logic [ACC_W-1:0]  first;
      logic [BASE_W-1:0] offset;  // symbol_base - first_code, modulo 512
   } jhd_entry_type;

   // table state seen by the decoder
   typedef struct packed {
      logic             ready;
      logic [LEN_W-1:0] longest;
   } jhd_info_type;

   // loader view of the current transaction
   typedef struct packed {
      jhd_status_type   status;
      logic             ready_next;
      logic [POS_W-1:0] pos_next;
   } jhd_load_res_type;

   // decoder view of the current transaction
   typedef struct packed {
      logic             hit;
      jhd_status_type   status;
      logic [LEN_W-1:0] code_length;
   } jhd_dec_res_type;

   // result waiting for the symbol memory read
   typedef struct packed {
      logic             hit;
      logic [LEN_W-1:0] code_length;
      jhd_status_type   status;
      logic             table_ready;
      logic [POS_W-1:0] bytes_loaded;
   } jhd_stage_type;

endpackage

// ===== rtl/core/jhd_if.sv =====
// ---------------------------------------------------------------------------
// jhd_if: valid/ready channels of the Huffman table decoder
// Request channel carries one mode/byte/bit transaction, response channel
// carries one decode result per request.
// ---------------------------------------------------------------------------
interface jhd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] table_byte;
   logic       code_bit;

   modport source (output valid, mode, table_byte, code_bit, input ready);
   modport sink   (input valid, mode, table_byte, code_bit, output ready);
endinterface

interface jhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       symbol_valid;
   logic [4:0] code_length;
   logic [2:0] status;
   logic       table_ready;
   logic [8:0] bytes_loaded;

   modport source (output valid, symbol, symbol_valid, code_length, status,
                   table_ready, bytes_loaded, input ready);
   modport sink   (input valid, symbol, symbol_valid, code_length, status,
                   table_ready, bytes_loaded, output ready);
endinterface

// ===== rtl/core/jpeg_huffman_table_decoder.sv =====
// ---------------------------------------------------------------------------
// jpeg_huffman_table_decoder: Huffman table load and bit-serial decode
// Loads a DHT-style table (16 counts, then symbols) and decodes one code
// bit per transaction, one response per request.
//
//   channel   direction  transaction
//   req_if    in         mode, table_byte, code_bit
//   rsp_if    out        symbol, symbol_valid, code_length, status,
//                        table_ready, bytes_loaded
//
// One request accepted per cycle, every mode, while the pipeline has room;
// response path: canonical compare and symbol memory read, then output register.
// The path length is set by the symbol memory's registered read port.
// Synchronous reset clears the table state; the symbol memory is not cleared.
// A stalled response holds the pipeline; requests keep flowing while the
// output register or the lookup stage has room.
// ---------------------------------------------------------------------------
module jpeg_huffman_table_decoder #(
   parameter int MAX_CODE_LEN = jhd_pkg::DEF_MAX_CODE_LEN,
   parameter int MAX_SYMBOLS  = jhd_pkg::DEF_MAX_SYMBOLS
) (
   input logic   clock,
   input logic   reset,
   jhd_req_if.sink   req_if,
   jhd_rsp_if.source rsp_if
);

   import jhd_pkg::*;

   localparam int LEN_IDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
   localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);

   jhd_mode_type     mode;
   logic             accept, out_free;
   logic [LEN_IDX_W-1:0] lut_index;
   jhd_entry_type    lut_entry;
   jhd_info_type     info;
   jhd_load_res_type load_res;
   jhd_dec_res_type  dec_res;
   logic             ram_wr_en, ram_rd_en;
   logic [SYM_IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;

   logic             s1_valid_ff, s1_valid_in;
   jhd_stage_type    s1_ff, s1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       symbol_ff;
   jhd_stage_type    out_ff;

   assign mode     = jhd_mode_type'(req_if.mode);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign accept   = req_if.valid && req_if.ready;

   jhd_loader #(.MAX_CODE_LEN(MAX_CODE_LEN), .MAX_SYMBOLS(MAX_SYMBOLS)) u_loader (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (mode),
      .table_byte  (req_if.table_byte),
      .lut_index   (lut_index),
      .lut_entry   (lut_entry),
      .info        (info),
      .load_res    (load_res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   jhd_decoder #(.MAX_CODE_LEN(MAX_CODE_LEN), .MAX_SYMBOLS(MAX_SYMBOLS)) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (mode),
      .code_bit    (req_if.code_bit),
      .info        (info),
      .lut_entry   (lut_entry),
      .lut_index   (lut_index),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .dec_res     (dec_res)
   );

   jhd_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_SYMBOLS)) u_symbol_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // lookup stage contents for the accepted transaction
   always_comb begin
      s1_in.hit          = dec_res.hit;
      s1_in.code_length  = dec_res.code_length;
      s1_in.table_ready  = load_res.ready_next;
      s1_in.bytes_loaded = load_res.pos_next;
      case (mode)
         MODE_TABLE: s1_in.status = load_res.status;
         MODE_BIT:   s1_in.status = dec_res.status;
         default:    s1_in.status = ST_OK;
      endcase
   end

   // pipeline occupancy
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (out_free && s1_valid_ff) begin
         out_ff    <= s1_ff;
         symbol_ff <= s1_ff.hit ? ram_rd_data : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.symbol       = symbol_ff;
   assign rsp_if.symbol_valid = out_ff.hit;
   assign rsp_if.code_length  = out_ff.code_length;
   assign rsp_if.status       = out_ff.status;
   assign rsp_if.table_ready  = out_ff.table_ready;
   assign rsp_if.bytes_loaded = out_ff.bytes_loaded;

   // the lookup stage is never overwritten while its result cannot move on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("lookup stage lost a pending transaction");

   // a decoded symbol always comes with an ok status and a table in place
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_ff.hit |-> (out_ff.status == ST_OK) && out_ff.table_ready)
      else $error("symbol reported with error status or no table");

   // code length stays within one bit past the longest code
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_ff.code_length <= LEN_W'(MAX_CODE_LEN + 1))
      else $error("code length out of range");

endmodule

// ===== rtl/core/jhd_ram.sv =====
// ---------------------------------------------------------------------------
// jhd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module jhd_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/jhd_loader.sv =====
// ---------------------------------------------------------------------------
// jhd_loader: table definition loader
// Takes count bytes then symbol bytes, builds the canonical code table one
// row per count byte, checks totals and free leaves, and writes symbols
// into the symbol memory.
// ---------------------------------------------------------------------------
module jhd_loader #(
   parameter  int MAX_CODE_LEN = jhd_pkg::DEF_MAX_CODE_LEN,
   parameter  int MAX_SYMBOLS  = jhd_pkg::DEF_MAX_SYMBOLS,
   localparam int LEN_IDX_W    = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1,
   localparam int SYM_IDX_W    = $clog2(MAX_SYMBOLS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  jhd_pkg::jhd_mode_type    mode,
   input  logic [7:0]               table_byte,
   input  logic [LEN_IDX_W-1:0]     lut_index,
   output jhd_pkg::jhd_entry_type   lut_entry,
   output jhd_pkg::jhd_info_type    info,
   output jhd_pkg::jhd_load_res_type load_res,
   output logic                     ram_wr_en,
   output logic [SYM_IDX_W-1:0]     ram_wr_addr,
   output logic [7:0]               ram_wr_data
);

   import jhd_pkg::*;

   // table rows and load state
   jhd_entry_type      entry_ff [MAX_CODE_LEN];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]   longest_ff, longest_in;
   logic               ready_ff, ready_in;
   logic               bad_ff, bad_in;
   logic               oversub_ff, oversub_in;
   logic [POS_W-1:0]   free_ff, free_in;
   logic [ACC_W-1:0]   code_ff, code_in;
   logic [BASE_W-1:0]  base_ff, base_in;

   logic               is_count, last_count, over_now, too_many, sym_done;
   logic               row_write, sym_write;
   logic [TOTAL_W-1:0] total_sum;
   logic [POS_W-1:0]   sym_idx, free_diff;
   logic [POS_W:0]     free_shift;
   logic [ACC_W-1:0]   code_sum;
   jhd_status_type     status;

   // per-byte canonical build arithmetic
   always_comb begin
      total_sum  = total_ff + TOTAL_W'(table_byte);
      over_now   = POS_W'(table_byte) > free_ff;
      is_count   = pos_ff < POS_W'(MAX_CODE_LEN);
      last_count = pos_ff == POS_W'(MAX_CODE_LEN - 1);
      too_many   = total_sum > TOTAL_W'(MAX_SYMBOLS);
      sym_idx    = pos_ff - POS_W'(MAX_CODE_LEN);
      sym_done   = (TOTAL_W'(sym_idx) + TOTAL_W'(1)) >= total_ff;
      free_diff  = free_ff - POS_W'(table_byte);
      free_shift = {free_diff, 1'b0};
      code_sum   = code_ff + ACC_W'(table_byte);
   end

   // next state of the load state, taken only when a transaction is accepted
   always_comb begin
      pos_in     = pos_ff;
      total_in   = total_ff;
      longest_in = longest_ff;
      ready_in   = ready_ff;
      bad_in     = bad_ff;
      oversub_in = oversub_ff;
      free_in    = free_ff;
      code_in    = code_ff;
      base_in    = base_ff;
      status     = ST_OK;
      row_write  = 1'b0;
      sym_write  = 1'b0;
      case (mode)
         MODE_RESTART: begin
            pos_in     = '0;
            total_in   = '0;
            longest_in = '0;
            ready_in   = 1'b0;
            bad_in     = 1'b0;
            oversub_in = 1'b0;
            free_in    = POS_W'(2);
            code_in    = '0;
            base_in    = '0;
         end
         MODE_TABLE: begin
            if (bad_ff) begin
               status = (total_ff > TOTAL_W'(MAX_SYMBOLS)) ? ST_TOO_MANY : ST_OVERSUB;
            end else if (!ready_ff) begin
               pos_in = pos_ff + POS_W'(1);
               if (is_count) begin
                  row_write  = 1'b1;
                  total_in   = total_sum;
                  oversub_in = oversub_ff | over_now;
                  if ((table_byte != '0) || (pos_ff == '0)) begin
                     longest_in = pos_ff[LEN_W-1:0] + LEN_W'(1);
                  end
                  free_in = (free_shift > (POS_W+1)'(FREE_CAP)) ?
                            POS_W'(FREE_CAP) : free_shift[POS_W-1:0];
                  code_in = {code_sum[ACC_W-2:0], 1'b0};
                  base_in = base_ff + BASE_W'(table_byte);
                  // checks run on the last count byte
                  if (last_count) begin
                     if (too_many) begin
                        status = ST_TOO_MANY;
                        bad_in = 1'b1;
                     end else if (oversub_ff || over_now) begin
                        status = ST_OVERSUB;
                        bad_in = 1'b1;
                     end else if (total_sum == '0) begin
                        ready_in = 1'b1;
                     end
                  end
               end else begin
                  sym_write = sym_idx < POS_W'(MAX_SYMBOLS);
                  if (sym_done) begin
                     ready_in = 1'b1;
                  end
               end
            end
         end
         MODE_BIT, MODE_UNUSED: begin
            status = ST_OK;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         total_ff   <= '0;
         longest_ff <= '0;
         ready_ff   <= 1'b0;
         bad_ff     <= 1'b0;
         oversub_ff <= 1'b0;
         free_ff    <= POS_W'(2);
         code_ff    <= '0;
         base_ff    <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         total_ff   <= total_in;
         longest_ff <= longest_in;
         ready_ff   <= ready_in;
         bad_ff     <= bad_in;
         oversub_ff <= oversub_in;
         free_ff    <= free_in;
         code_ff    <= code_in;
         base_ff    <= base_in;
      end
   end

   // table rows, only read once the whole table is in
   always_ff @(posedge clock) begin
      if (accept && row_write) begin
         entry_ff[pos_ff[LEN_IDX_W-1:0]] <= '{
            count:  table_byte,
            first:  code_ff,
            offset: base_ff - code_ff[BASE_W-1:0]
         };
      end
   end

   assign lut_entry   = entry_ff[lut_index];
   assign info        = '{ready: ready_ff, longest: longest_ff};
   assign load_res    = '{status: status, ready_next: ready_in, pos_next: pos_in};
   assign ram_wr_en   = accept && sym_write;
   assign ram_wr_addr = sym_idx[SYM_IDX_W-1:0];
   assign ram_wr_data = table_byte;

   // a table is never both ready and rejected
   a_ready_bad: assert property (@(posedge clock) disable iff (reset)
      !(ready_ff && bad_ff))
      else $error("table marked ready and bad at once");

   // symbol bytes never run past the symbol store
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_CODE_LEN + MAX_SYMBOLS))
      else $error("load position beyond table size");

   // no symbol written before the count bytes are complete
   a_sym_after_counts: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (pos_ff >= POS_W'(MAX_CODE_LEN)) && !ready_ff && !bad_ff)
      else $error("symbol write outside symbol phase");

endmodule

// ===== rtl/core/jhd_decoder.sv =====
// ---------------------------------------------------------------------------
// jhd_decoder: bit-serial canonical code matcher
// Shifts one code bit into the accumulator, compares against the canonical
// row for the new length and issues the symbol memory read on a match.
// ---------------------------------------------------------------------------
module jhd_decoder #(
   parameter  int MAX_CODE_LEN = jhd_pkg::DEF_MAX_CODE_LEN,
   parameter  int MAX_SYMBOLS  = jhd_pkg::DEF_MAX_SYMBOLS,
   localparam int LEN_IDX_W    = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1,
   localparam int SYM_IDX_W    = $clog2(MAX_SYMBOLS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  jhd_pkg::jhd_mode_type   mode,
   input  logic                    code_bit,
   input  jhd_pkg::jhd_info_type   info,
   input  jhd_pkg::jhd_entry_type  lut_entry,
   output logic [LEN_IDX_W-1:0]    lut_index,
   output logic                    ram_rd_en,
   output logic [SYM_IDX_W-1:0]    ram_rd_addr,
   output jhd_pkg::jhd_dec_res_type dec_res
);

   import jhd_pkg::*;

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LEN_W-1:0]  bits_ff, bits_in;
   logic [ACC_W-1:0]  acc_new, diff;
   logic [LEN_W-1:0]  n;
   logic [BASE_W-1:0] sym_idx;
   logic              in_range, hit, term;
   jhd_status_type    status;
   logic [LEN_W-1:0]  code_length;

   // canonical compare for the length this bit reaches
   always_comb begin
      n        = bits_ff + LEN_W'(1);
      acc_new  = {acc_ff[ACC_W-2:0], code_bit};
      in_range = (n <= info.longest) && (n <= LEN_W'(MAX_CODE_LEN));
      diff     = acc_new - lut_entry.first;
      hit      = in_range && (acc_new >= lut_entry.first) &&
                 (diff < ACC_W'(lut_entry.count));
      term     = hit || (n > info.longest);
      sym_idx  = lut_entry.offset + acc_new[BASE_W-1:0];
   end

   // accumulator update and per-transaction result
   always_comb begin
      acc_in      = acc_ff;
      bits_in     = bits_ff;
      status      = ST_OK;
      code_length = bits_ff;
      case (mode)
         MODE_RESTART: begin
            acc_in      = '0;
            bits_in     = '0;
            code_length = '0;
         end
         MODE_BIT: begin
            if (!info.ready) begin
               status = ST_NO_TABLE;
            end else begin
               code_length = n;
               if (term) begin
                  acc_in  = '0;
                  bits_in = '0;
                  if (!hit) begin
                     status = ST_INVALID;
                  end
               end else begin
                  acc_in  = acc_new;
                  bits_in = n;
               end
            end
         end
         MODE_TABLE, MODE_UNUSED: begin
            status = ST_OK;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         bits_ff <= '0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         bits_ff <= bits_in;
      end
   end

   assign lut_index   = bits_ff[LEN_IDX_W-1:0];
   assign ram_rd_en   = accept && (mode == MODE_BIT) && info.ready && hit;
   assign ram_rd_addr = sym_idx[SYM_IDX_W-1:0];
   assign dec_res     = '{hit: (mode == MODE_BIT) && info.ready && hit,
                          status: status, code_length: code_length};

   // a pending code never grows past the longest length in use
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= info.longest)
      else $error("pending code longer than longest length");

   // without a table the accumulator stays empty
   a_idle_without_table: assert property (@(posedge clock) disable iff (reset)
      !info.ready |-> (bits_ff == '0) && (acc_ff == '0))
      else $error("code bits held without a ready table");

endmodule

// ===== verif/tb_jpeg_huffman_table_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_jpeg_huffman_table_decoder: self-checking bench for the Huffman decoder
// Loads canonical tables (well-formed, empty, over-count, oversubscribed,
// truncated, full 256-symbol and 16-bit deep), decodes code streams built
// from them plus random noise, and checks every response field against an
// in-bench model of the loader and the bit decoder. Both channels idle in
// random bursts; the response side is also held off for a long stretch.
// ---------------------------------------------------------------------------
module tb_jpeg_huffman_table_decoder;
   import jhd_pkg::*;

   // one request transaction, tagged with the idling level of its session
   typedef struct {
      jhd_mode_type mode;
      logic [7:0]   tbyte;
      logic         cbit;
      int           gap_pct;
   } huff_req_t;

   // one response transaction
   typedef struct {
      logic [7:0]     symbol;
      logic           hit;
      logic [4:0]     clen;
      jhd_status_type status;
      logic           ready;
      logic [8:0]     nbytes;
   } huff_rsp_t;

   typedef enum int {
      SES_VALID, SES_EMPTY, SES_TOO_MANY, SES_OVERSUB, SES_BROKEN, SES_FULL, SES_DEEP
   } session_kind_e;

   localparam int NUM_LENGTHS = 16;
   localparam int SYM_DEPTH   = 256;
   localparam int WORK_ITEMS  = 1350;
   localparam int HOLD_CYCLES = 60;

   logic clock;
   logic reset;

   jhd_req_if req_bus ();
   jhd_rsp_if rsp_bus ();

   jpeg_huffman_table_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // clock: 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   huff_req_t stim_q[$];
   huff_rsp_t decode_out_q[$];
   huff_req_t cur_req;

   int   idle_pct   = 0;
   int   tx_gap     = 0;
   int   rx_gap     = 0;
   logic long_hold  = 1'b0;
   int   n_accepted = 0;
   int   work_items = 0;
   int   n_errors   = 0;
   int   n_rsp      = 0;
   int   n_sym      = 0;
   int   n_invalid  = 0;
   int   n_no_table = 0;
   int   n_too_many = 0;
   int   n_oversub  = 0;
   int   deepest    = 0;

   // table the stimulus is currently built from
   int gen_cnt[NUM_LENGTHS];
   int gen_total;
   int gen_pct = 0;

   // ------------------------------------------------------------------------
   // Decoder model state
   // ------------------------------------------------------------------------
   logic [7:0]  m_count [NUM_LENGTHS];
   logic [16:0] m_first [NUM_LENGTHS];
   logic [8:0]  m_base  [NUM_LENGTHS];
   logic [7:0]  m_syms  [SYM_DEPTH];
   logic [8:0]  m_pos;
   logic [11:0] m_total;
   logic [4:0]  m_longest;
   logic        m_ready;
   logic        m_bad;
   logic [16:0] m_acc;
   logic [4:0]  m_nbits;

   // restart: table and decoder cleared, symbol store kept
   task automatic model_clear();
      foreach (m_count[i]) begin
         m_count[i] = '0;
         m_first[i] = '0;
         m_base[i]  = '0;
      end
      m_pos     = '0;
      m_total   = '0;
      m_longest = '0;
      m_ready   = 1'b0;
      m_bad     = 1'b0;
      m_acc     = '0;
      m_nbits   = '0;
   endtask

   // canonical first codes and symbol offsets, checked for over-count and
   // oversubscription
   function automatic jhd_status_type build_canonical();
      int unsigned leaves = 2;
      int unsigned code   = 0;
      int unsigned base   = 0;
      if (m_total > SYM_DEPTH) return ST_TOO_MANY;
      m_longest = 5'd1;
      for (int i = 0; i < NUM_LENGTHS; i++) begin
         if (m_count[i] != 0) m_longest = 5'(i + 1);
         if (m_count[i] > leaves) return ST_OVERSUB;
         m_first[i] = 17'(code);
         m_base[i]  = 9'(base);
         base   = base + m_count[i];
         code   = (code + m_count[i]) << 1;
         leaves = (leaves - m_count[i]) << 1;
      end
      return ST_OK;
   endfunction

   // apply one accepted request to the model, queue the response it gives
   task automatic dht_apply(input huff_req_t it);
      huff_rsp_t   r;
      int unsigned n, fc, accv, idx;
      logic        done;
      r.symbol = '0;
      r.hit    = 1'b0;
      r.status = ST_OK;
      done     = 1'b0;
      n        = 0;
      case (it.mode)
         MODE_RESTART: model_clear();
         MODE_TABLE: begin
            if (m_bad) begin
               r.status = (m_total > SYM_DEPTH) ? ST_TOO_MANY : ST_OVERSUB;
            end else if (!m_ready) begin
               if (m_pos < NUM_LENGTHS) begin
                  m_count[m_pos] = it.tbyte;
                  m_total = m_total + it.tbyte;
                  m_pos = m_pos + 9'd1;
                  if (m_pos == NUM_LENGTHS) begin
                     r.status = build_canonical();
                     if (r.status != ST_OK) m_bad = 1'b1;
                     else if (m_total == 0) m_ready = 1'b1;
                  end
               end else begin
                  idx = m_pos - NUM_LENGTHS;
                  if (idx < SYM_DEPTH) m_syms[idx] = it.tbyte;
                  m_pos = m_pos + 9'd1;
                  if (idx + 1 >= m_total) m_ready = 1'b1;
               end
            end
         end
         MODE_BIT: begin
            if (!m_ready) begin
               r.status = ST_NO_TABLE;
            end else begin
               m_acc   = {m_acc[15:0], it.cbit};
               m_nbits = m_nbits + 5'd1;
               n       = m_nbits;
               accv    = m_acc;
               if (n >= 1 && n <= m_longest && n <= NUM_LENGTHS) begin
                  fc = m_first[n-1];
                  if (accv >= fc && accv - fc < m_count[n-1]) begin
                     idx = m_base[n-1] + (accv - fc);
                     if (idx < SYM_DEPTH) r.symbol = m_syms[idx];
                     r.hit = 1'b1;
                  end
               end
               // a code ends on a match or one bit past the longest length
               if (r.hit || n > m_longest) begin
                  if (!r.hit) r.status = ST_INVALID;
                  done    = 1'b1;
                  m_acc   = '0;
                  m_nbits = '0;
               end
            end
         end
         default: ;
      endcase
      r.clen   = done ? 5'(n) : m_nbits;
      r.ready  = m_ready;
      r.nbytes = m_pos;
      decode_out_q.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic go;
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap = 0;
         model_clear();
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            dht_apply(cur_req);
            n_accepted++;
         end
         go = 1'b0;
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (stim_q.size() != 0) begin
            if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
               tx_gap = $urandom_range(4, 0);
            end else begin
               go = 1'b1;
            end
         end
         if (go) begin
            cur_req = stim_q.pop_front();
            req_bus.mode       <= cur_req.mode;
            req_bus.table_byte <= cur_req.tbyte;
            req_bus.code_bit   <= cur_req.cbit;
            idle_pct           <= cur_req.gap_pct;
         end
         req_bus.valid <= go;
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor and checker
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      n_errors++;
      if (n_errors <= 30)
         $display("MISMATCH response %0d %s: got %0d, want %0d", n_rsp, what, got, want);
   endtask

   always @(posedge clock) begin : rsp_monitor
      huff_rsp_t want;
      logic      rdy;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decode_out_q.size() == 0) begin
               note_mismatch("with nothing outstanding", rsp_bus.status, 0);
            end else begin
               want = decode_out_q.pop_front();
               if (rsp_bus.symbol !== want.symbol)
                  note_mismatch("symbol", rsp_bus.symbol, want.symbol);
               if (rsp_bus.symbol_valid !== want.hit)
                  note_mismatch("symbol_valid", rsp_bus.symbol_valid, want.hit);
               if (rsp_bus.code_length !== want.clen)
                  note_mismatch("code_length", rsp_bus.code_length, want.clen);
               if (rsp_bus.status !== want.status)
                  note_mismatch("status", rsp_bus.status, want.status);
               if (rsp_bus.table_ready !== want.ready)
                  note_mismatch("table_ready", rsp_bus.table_ready, want.ready);
               if (rsp_bus.bytes_loaded !== want.nbytes)
                  note_mismatch("bytes_loaded", rsp_bus.bytes_loaded, want.nbytes);
               if (want.hit) begin
                  n_sym++;
                  if (want.clen > deepest) deepest = want.clen;
               end
               case (want.status)
                  ST_INVALID:  n_invalid++;
                  ST_NO_TABLE: n_no_table++;
                  ST_TOO_MANY: n_too_many++;
                  ST_OVERSUB:  n_oversub++;
                  default: ;
               endcase
            end
            n_rsp++;
         end
         // ready: long hold-off, then random bursts of back-pressure
         if (long_hold) begin
            rdy = 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rdy = 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            rx_gap = $urandom_range(4, 0);
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_bus.ready <= rdy;
      end
   end

   // long receiver stall while the request side still has plenty queued
   initial begin : rsp_hold_off
      while (n_accepted < 300 || stim_q.size() < 20) @(negedge clock);
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      long_hold = 1'b0;
   end

   // run limit
   initial begin : watchdog
      #400000;
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------
   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(255, 0));
   endfunction

   // symbol bytes lean on the extremes now and then
   function automatic logic [7:0] sym_byte();
      case ($urandom_range(7, 0))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return rnd_byte();
      endcase
   endfunction

   task automatic push_req(input jhd_mode_type m, input logic [7:0] b, input logic c);
      huff_req_t it;
      it.mode    = m;
      it.tbyte   = b;
      it.cbit    = c;
      it.gap_pct = gen_pct;
      stim_q.push_back(it);
      if (m != MODE_UNUSED) work_items++;
   endtask

   task automatic push_counts();
      for (int i = 0; i < NUM_LENGTHS; i++)
         push_req(MODE_TABLE, 8'(gen_cnt[i]), 1'($urandom_range(1, 0)));
   endtask

   // symbol bytes, with the odd early code bit or unused mode slipped in
   task automatic push_symbols(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(39, 0))
            0:       push_req(MODE_BIT, rnd_byte(), 1'($urandom_range(1, 0)));
            1:       push_req(MODE_UNUSED, rnd_byte(), 1'($urandom_range(1, 0)));
            default: ;
         endcase
         push_req(MODE_TABLE, sym_byte(), 1'($urandom_range(1, 0)));
      end
   endtask

   task automatic push_noise_bits(input int n);
      repeat (n) push_req(MODE_BIT, rnd_byte(), 1'($urandom_range(1, 0)));
   endtask

   // random counts forming a valid canonical tree
   task automatic pick_counts(input int budget, input int maxlen);
      int leaves, cap, c;
      leaves    = 2;
      gen_total = 0;
      foreach (gen_cnt[i]) gen_cnt[i] = 0;
      for (int i = 0; i < maxlen; i++) begin
         cap = (leaves > 255) ? 255 : leaves;
         if (cap > budget - gen_total) cap = budget - gen_total;
         if (i == maxlen - 1) begin
            if (cap == 0) c = 0;
            else if ($urandom_range(1, 0) == 1) c = cap;
            else c = $urandom_range(cap, 1);
         end else if ($urandom_range(3, 0) == 0) begin
            c = $urandom_range(cap, 0);
         end else begin
            c = $urandom_range((cap < 2) ? cap : 2, 0);
         end
         gen_cnt[i] = c;
         gen_total += c;
         leaves = (leaves - c) * 2;
      end
   endtask

   // canonical code of symbol index k, sent most significant bit first
   task automatic push_code(input int k);
      int code, base;
      code = 0;
      base = 0;
      for (int len = 1; len <= NUM_LENGTHS; len++) begin
         if (k < base + gen_cnt[len-1]) begin
            code += k - base;
            for (int b = len - 1; b >= 0; b--)
               push_req(MODE_BIT, rnd_byte(), 1'((code >> b) & 1));
            return;
         end
         base += gen_cnt[len-1];
         code = (code + gen_cnt[len-1]) << 1;
      end
   endtask

   // mostly real codes, some noise, ignored bytes and unused modes
   task automatic push_stream(input int ncodes, input bit deep);
      int r;
      repeat (ncodes) begin
         r = $urandom_range(99, 0);
         if (r < 78) begin
            if (deep && r < 40) push_code(gen_total - 1 - $urandom_range(1, 0));
            else push_code($urandom_range(gen_total - 1, 0));
         end else if (r < 90) begin
            push_noise_bits($urandom_range(17, 1));
         end else if (r < 95) begin
            push_req(MODE_UNUSED, rnd_byte(), 1'($urandom_range(1, 0)));
         end else begin
            push_req(MODE_TABLE, rnd_byte(), 1'($urandom_range(1, 0)));
         end
      end
   endtask

   task automatic run_session(input session_kind_e kind);
      int p;
      push_req(MODE_RESTART, rnd_byte(), 1'($urandom_range(1, 0)));
      case (kind)
         SES_VALID: begin
            pick_counts(($urandom_range(4, 0) != 0) ? $urandom_range(24, 2)
                                                    : $urandom_range(256, 25),
                        ($urandom_range(6, 0) != 0) ? $urandom_range(8, 1)
                                                    : $urandom_range(16, 9));
            push_counts();
            push_symbols(gen_total);
            if ($urandom_range(3, 0) == 0) begin
               repeat ($urandom_range(3, 1))
                  push_req(MODE_TABLE, rnd_byte(), 1'($urandom_range(1, 0)));
            end
            push_stream($urandom_range(20, 4), 1'b0);
         end
         SES_EMPTY: begin
            pick_counts(0, 0);
            push_counts();
            push_noise_bits($urandom_range(7, 3));
            if ($urandom_range(1, 0) == 1) push_req(MODE_TABLE, rnd_byte(), 1'b0);
         end
         SES_TOO_MANY: begin
            gen_total = 0;
            foreach (gen_cnt[i]) begin
               gen_cnt[i] = $urandom_range(255, 0);
               gen_total += gen_cnt[i];
            end
            if (gen_total <= SYM_DEPTH) gen_cnt[NUM_LENGTHS-1] = 255;
            push_counts();
            repeat ($urandom_range(3, 1)) push_req(MODE_TABLE, rnd_byte(), 1'b1);
            push_noise_bits($urandom_range(2, 1));
         end
         SES_OVERSUB: begin
            foreach (gen_cnt[i]) gen_cnt[i] = 0;
            if ($urandom_range(1, 0) == 1) begin
               // too many codes at one length with nothing shorter
               p = $urandom_range(6, 0);
               gen_cnt[p] = (2 << p) + $urandom_range(8, 1);
            end else begin
               // shorter codes leave too few leaves for length two
               p = 1;
               gen_cnt[0] = $urandom_range(2, 1);
               gen_cnt[1] = (2 - gen_cnt[0]) * 2 + $urandom_range(3, 1);
            end
            for (int i = p + 1; i < NUM_LENGTHS; i++) gen_cnt[i] = $urandom_range(3, 0);
            push_counts();
            repeat ($urandom_range(3, 1)) push_req(MODE_TABLE, rnd_byte(), 1'b0);
            push_noise_bits(1);
         end
         SES_BROKEN: begin
            pick_counts($urandom_range(12, 1), $urandom_range(6, 1));
            if ($urandom_range(1, 0) == 1) begin
               for (int i = 0; i < $urandom_range(15, 1); i++)
                  push_req(MODE_TABLE, 8'(gen_cnt[i]), 1'b0);
            end else begin
               push_counts();
               push_symbols($urandom_range(gen_total - 1, 0));
            end
            push_noise_bits($urandom_range(3, 1));
         end
         SES_FULL: begin
            // 256 symbols: 255 codes of eight bits, one of nine
            foreach (gen_cnt[i]) gen_cnt[i] = 0;
            gen_cnt[7] = 255;
            gen_cnt[8] = 1;
            gen_total  = 256;
            push_counts();
            push_symbols(gen_total);
            push_stream(20, 1'b1);
         end
         SES_DEEP: begin
            // one code at each length and two at sixteen bits
            foreach (gen_cnt[i]) gen_cnt[i] = 1;
            gen_cnt[NUM_LENGTHS-1] = 2;
            gen_total = 17;
            push_counts();
            push_symbols(gen_total);
            push_stream(12, 1'b1);
         end
         default: ;
      endcase
   endtask

   // hold the sender until every outstanding response has been checked
   task automatic wait_drained();
      while (stim_q.size() != 0 || req_bus.valid || decode_out_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      session_kind_e kind;
      int            s, r;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_UNUSED;
      req_bus.table_byte = '0;
      req_bus.code_bit   = 1'b0;
      rsp_bus.ready      = 1'b0;

      // directed: unused mode, bits with no table, empty table, invalid
      // code after two bits, pending length, extra byte, restart
      gen_pct = 0;
      push_req(MODE_UNUSED, 8'hff, 1'b1);
      push_req(MODE_BIT, 8'h00, 1'b1);
      push_req(MODE_BIT, 8'hff, 1'b0);
      push_req(MODE_RESTART, 8'hff, 1'b1);
      repeat (NUM_LENGTHS) push_req(MODE_TABLE, 8'h00, 1'b1);
      push_req(MODE_BIT, 8'h5a, 1'b1);
      push_req(MODE_UNUSED, 8'h00, 1'b0);
      push_req(MODE_BIT, 8'ha5, 1'b0);
      push_req(MODE_TABLE, 8'hff, 1'b0);
      push_req(MODE_RESTART, 8'h00, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sessions: each kind once, then a weighted random mix
      s = 0;
      while (work_items < WORK_ITEMS) begin
         if (s < 7) begin
            kind = session_kind_e'(s);
         end else begin
            r = $urandom_range(99, 0);
            if (r < 62)      kind = SES_VALID;
            else if (r < 70) kind = SES_EMPTY;
            else if (r < 77) kind = SES_TOO_MANY;
            else if (r < 84) kind = SES_OVERSUB;
            else if (r < 92) kind = SES_BROKEN;
            else if (r < 99) kind = SES_DEEP;
            else             kind = SES_FULL;
         end
         // last part of the run goes without idling
         if (work_items > WORK_ITEMS - 200) begin
            gen_pct = 0;
         end else begin
            case ($urandom_range(3, 0))
               0:       gen_pct = 0;
               1:       gen_pct = 10;
               2:       gen_pct = 30;
               default: gen_pct = 50;
            endcase
         end
         run_session(kind);
         if (s >= 8 && s % 4 == 3) wait_drained();
         s++;
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Checked %0d responses over %0d sessions: %0d symbols (longest %0d bits),",
               n_rsp, s, n_sym, deepest);
      $display("  %0d invalid codes, %0d bits without table, %0d over-count, %0d oversubscribed",
               n_invalid, n_no_table, n_too_many, n_oversub);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/jhd_pkg.sv
rtl/core/jhd_if.sv
rtl/core/jhd_ram.sv
rtl/core/jhd_loader.sv
rtl/core/jhd_decoder.sv
rtl/core/jpeg_huffman_table_decoder.sv
verif/tb_jpeg_huffman_table_decoder.sv
